// File: rtl/rlmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmc_pkg
// Types, register map and constants shared by the rgb led mode controller.
// ----------------------------------------------------------------------------
package rlmc_pkg;

  localparam int LevelW   = 8;
  localparam int WidthW   = 15;
  localparam int LoadW    = 16;
  localparam int TicksW   = 8;
  localparam int SpeedW   = 7;
  localparam int ProdW    = LevelW + LoadW;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  typedef logic [LevelW-1:0] level_t;

  localparam level_t LEVEL_MAX = 8'd254;
  localparam level_t LEVEL_MIN = 8'd10;
  localparam logic [SpeedW-1:0] SPEED_MAX = 7'd100;
  localparam logic [SpeedW-1:0] SPEED_MIN = 7'd1;
  localparam logic [TicksW-1:0] COUNT_MAX = 8'd255;
  localparam logic [1:0] PRESS_MAX = 2'd3;

  // speed / 10 as a multiply by a rounded-up reciprocal, exact for 7-bit speeds
  localparam int SpeedDiv    = 10;
  localparam int SpeedShift  = 11;
  localparam logic [7:0] SPEED_RECIP = 8'(((1 << SpeedShift) + SpeedDiv - 1) / SpeedDiv);

  // level * load / 1000 via reciprocal, exact for products below 2^24
  localparam longint WidthDiv   = 1000;
  localparam int     RecipShift = 34;
  localparam int     RecipW     = 25;
  localparam logic [RecipW-1:0] RECIP_MULT =
    RecipW'(((64'd1 << RecipShift) + WidthDiv - 1) / WidthDiv);

  localparam logic [LoadW-1:0]  PERIOD_LOAD_RST = 16'd11362;
  localparam logic [TicksW-1:0] LONG_PRESS_RST  = 8'd20;
  localparam logic [TicksW-1:0] TIMEOUT_RST     = 8'd20;

  typedef enum logic [1:0] {
    REG_PERIOD_LOAD = 2'd0,
    REG_LONG_PRESS  = 2'd1,
    REG_TIMEOUT     = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_AUTO  = 2'd0,
    MODE_RED   = 2'd1,
    MODE_GREEN = 2'd2,
    MODE_BLUE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [LoadW-1:0]  period_load;
    logic [TicksW-1:0] long_press_ticks;
    logic [TicksW-1:0] timeout_ticks;
  } cfg_t;

  // one tick's levels and mode on their way to the scaling stages
  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
    mode_t  mode;
  } color_t;

endpackage

// File: rtl/rlmc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmc channel interfaces
// Valid/ready channels for button ticks and for color results.
// ----------------------------------------------------------------------------
interface rlmc_tick_if;
  import rlmc_pkg::*;
  logic valid;
  logic ready;
  logic button_one;
  logic button_two;

  modport source (output valid, button_one, button_two, input ready);
  modport sink   (input valid, button_one, button_two, output ready);
endinterface

interface rlmc_result_if;
  import rlmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] red_level;
  logic [LevelW-1:0] green_level;
  logic [LevelW-1:0] blue_level;
  logic [WidthW-1:0] red_width;
  logic [WidthW-1:0] green_width;
  logic [WidthW-1:0] blue_width;
  logic [1:0]        mode;

  modport source (output valid, red_level, green_level, blue_level,
                  red_width, green_width, blue_width, mode, input ready);
  modport sink   (input valid, red_level, green_level, blue_level,
                  red_width, green_width, blue_width, mode, output ready);
endinterface

// File: rtl/rlmc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmc_cfg
// APB register file: period load, long press and timeout thresholds.
// ----------------------------------------------------------------------------
module rlmc_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rlmc_pkg::AddrW-1:0] paddr,
  input  logic [rlmc_pkg::DataW-1:0] pwdata,
  output logic [rlmc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output rlmc_pkg::cfg_t            cfg
);
  import rlmc_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_load      <= PERIOD_LOAD_RST;
      cfg.long_press_ticks <= LONG_PRESS_RST;
      cfg.timeout_ticks    <= TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PERIOD_LOAD: cfg.period_load      <= pwdata[LoadW-1:0];
        REG_LONG_PRESS:  cfg.long_press_ticks <= pwdata[TicksW-1:0];
        REG_TIMEOUT:     cfg.timeout_ticks    <= pwdata[TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PERIOD_LOAD: prdata = DataW'(cfg.period_load);
      REG_LONG_PRESS:  prdata = DataW'(cfg.long_press_ticks);
      REG_TIMEOUT:     prdata = DataW'(cfg.timeout_ticks);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: rtl/rlmc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmc_core
// Gesture decode, mode selection, fade and manual level update per tick.
// ----------------------------------------------------------------------------
module rlmc_core (
  input  logic             clk,
  input  logic             rst,
  input  rlmc_pkg::cfg_t   cfg,
  rlmc_tick_if.sink        tick,
  input  logic             pass_ready,
  output logic             color_valid,
  output rlmc_pkg::color_t color
);
  import rlmc_pkg::*;

  logic [TicksW-1:0] hold_two_count, hold_one_count, release_count;
  logic [1:0]        short_press_count;
  mode_t             mode_reg;
  level_t            red_reg, green_reg, blue_reg;
  logic              fade_red_green, fade_green_blue, fade_blue_red;
  logic [SpeedW-1:0] fade_speed;

  logic [TicksW:0]   h2, h1, rc;
  logic [1:0]        sp;
  mode_t             m;
  logic [LevelW:0]   r, g, b, lvl;
  logic              frg, fgb, fbr;
  logic [SpeedW:0]   spd;
  logic [3:0]        d;
  logic [SpeedW+7:0] d_full;
  logic [TicksW:0]   thr, tmo;
  logic              accept;

  assign accept     = tick.valid && tick.ready;
  assign tick.ready = !color_valid || pass_ready;
  assign thr        = {1'b0, cfg.long_press_ticks};
  assign tmo        = {1'b0, cfg.timeout_ticks};
  assign d_full     = (SpeedW+8)'(fade_speed) * (SpeedW+8)'(SPEED_RECIP);
  assign d          = d_full[SpeedShift +: 4];

  always_comb begin
    h2  = {1'b0, hold_two_count};
    h1  = {1'b0, hold_one_count};
    rc  = {1'b0, release_count};
    sp  = short_press_count;
    m   = mode_reg;
    r   = {1'b0, red_reg};
    g   = {1'b0, green_reg};
    b   = {1'b0, blue_reg};
    frg = fade_red_green;
    fgb = fade_green_blue;
    fbr = fade_blue_red;
    spd = {1'b0, fade_speed};
    lvl = '0;

    // button two hold, a fresh press restarts the button one counters
    if (tick.button_two) begin
      if (hold_two_count == '0) begin
        h1 = '0;
        sp = '0;
        rc = '0;
      end
      h2 = h2 + 1'b1;
      if (h2 >= thr) h2 = thr;
    end else begin
      h2 = '0;
    end

    if (tick.button_one) begin
      if (h1 < {1'b0, COUNT_MAX}) h1 = h1 + 1'b1;
      rc = '0;
      if (sp == '0 && h1 >= thr) h1 = thr;
    end else begin
      rc = rc + 1'b1;
      if (rc >= tmo) rc = tmo;
      if (h1 < thr && h1 != '0 && sp < PRESS_MAX) sp = sp + 1'b1;
      h1 = '0;
    end

    if (h2 == thr) begin
      if (sp == 2'd2) begin
        m = MODE_GREEN;
      end else if (sp == 2'd1 && rc == tmo) begin
        m = MODE_RED;
      end else if (h1 == thr) begin
        m = MODE_BLUE;
      end
      if (m != mode_reg || sp == 2'd2 || (sp == 2'd1 && rc == tmo) || h1 == thr) begin
        r  = {1'b0, LEVEL_MIN};
        g  = {1'b0, LEVEL_MIN};
        b  = {1'b0, LEVEL_MIN};
        unique case (m)
          MODE_RED:   r = {1'b0, LEVEL_MAX};
          MODE_GREEN: g = {1'b0, LEVEL_MAX};
          default:    b = {1'b0, LEVEL_MAX};
        endcase
        h2 = '0;
        h1 = '0;
        sp = '0;
        rc = '0;
      end
    end

    if (m == MODE_AUTO) begin
      if (frg) begin
        r = (r >= 9'(d)) ? r - 9'(d) : '0;
        g = g + 9'(d);
      end else if (fgb) begin
        g = (g >= 9'(d)) ? g - 9'(d) : '0;
        b = b + 9'(d);
      end else if (fbr) begin
        b = (b >= 9'(d)) ? b - 9'(d) : '0;
        r = r + 9'(d);
      end
      if (r < {1'b0, LEVEL_MIN}) r = {1'b0, LEVEL_MIN};
      if (g < {1'b0, LEVEL_MIN}) g = {1'b0, LEVEL_MIN};
      if (b < {1'b0, LEVEL_MIN}) b = {1'b0, LEVEL_MIN};
      if (r > {1'b0, LEVEL_MAX}) begin
        r = {1'b0, LEVEL_MAX};
        fbr = 1'b0;
        frg = 1'b1;
      end
      if (g > {1'b0, LEVEL_MAX}) begin
        g = {1'b0, LEVEL_MAX};
        frg = 1'b0;
        fgb = 1'b1;
      end
      if (b > {1'b0, LEVEL_MAX}) begin
        b = {1'b0, LEVEL_MAX};
        fgb = 1'b0;
        fbr = 1'b1;
      end
      if (tick.button_two && spd > {1'b0, SPEED_MIN}) spd = spd - 1'b1;
      if (tick.button_two && spd < {1'b0, SPEED_MIN}) spd = {1'b0, SPEED_MIN};
      if (tick.button_one) begin
        spd = spd + 1'b1;
        if (spd > {1'b0, SPEED_MAX}) spd = {1'b0, SPEED_MAX};
      end
    end else begin
      unique case (m)
        MODE_RED:   lvl = r;
        MODE_GREEN: lvl = g;
        default:    lvl = b;
      endcase
      // raise first, then lower; a wrap below zero clamps high like the count
      if (tick.button_two) begin
        lvl = lvl + 1'b1;
        if (lvl < {1'b0, LEVEL_MIN}) lvl = {1'b0, LEVEL_MIN};
        if (lvl > {1'b0, LEVEL_MAX}) lvl = {1'b0, LEVEL_MAX};
      end
      if (tick.button_one) begin
        lvl = lvl - 1'b1;
        if (lvl < {1'b0, LEVEL_MIN}) lvl = {1'b0, LEVEL_MIN};
        if (lvl > {1'b0, LEVEL_MAX}) lvl = {1'b0, LEVEL_MAX};
      end
      unique case (m)
        MODE_RED:   r = lvl;
        MODE_GREEN: g = lvl;
        default:    b = lvl;
      endcase
    end
  end

  // the state registers double as the first pipeline stage
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_two_count    <= '0;
      hold_one_count    <= '0;
      short_press_count <= '0;
      release_count     <= '0;
      mode_reg          <= MODE_AUTO;
      red_reg           <= LEVEL_MAX;
      green_reg         <= LEVEL_MIN;
      blue_reg          <= LEVEL_MIN;
      fade_red_green    <= 1'b1;
      fade_green_blue   <= 1'b0;
      fade_blue_red     <= 1'b0;
      fade_speed        <= SPEED_MIN;
      color_valid       <= 1'b0;
    end else begin
      if (accept) begin
        hold_two_count    <= h2[TicksW-1:0];
        hold_one_count    <= h1[TicksW-1:0];
        short_press_count <= sp;
        release_count     <= rc[TicksW-1:0];
        mode_reg          <= m;
        red_reg           <= r[LevelW-1:0];
        green_reg         <= g[LevelW-1:0];
        blue_reg          <= b[LevelW-1:0];
        fade_red_green    <= frg;
        fade_green_blue   <= fgb;
        fade_blue_red     <= fbr;
        fade_speed        <= spd[SpeedW-1:0];
      end
      if (tick.ready) color_valid <= accept;
    end
  end

  assign color.red   = red_reg;
  assign color.green = green_reg;
  assign color.blue  = blue_reg;
  assign color.mode  = mode_reg;

endmodule

// File: rtl/rlmc_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmc_scale
// Two-stage pulse width scaling: level times load, then divide by 1000.
// ----------------------------------------------------------------------------
module rlmc_scale (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rlmc_pkg::LoadW-1:0] period_load,
  input  logic                       color_valid,
  input  rlmc_pkg::color_t           color,
  output logic                       pass_ready,
  rlmc_result_if.source              result
);
  import rlmc_pkg::*;

  localparam int QW = ProdW + RecipW;

  logic                    prod_valid;
  color_t                  prod_color;
  logic [2:0][ProdW-1:0]   prod;
  logic [2:0][LevelW-1:0]  lvl_in;
  logic [2:0][WidthW-1:0]  width_next;
  logic [2:0][WidthW-1:0]  width;
  logic [2:0][QW-1:0]      q_full;
  color_t                  out_color;
  logic                    out_ready, prod_ready;

  assign out_ready  = !result.valid || result.ready;
  assign prod_ready = !prod_valid || out_ready;
  assign pass_ready = prod_ready;

  assign lvl_in = {color.blue, color.green, color.red};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_full[i]     = QW'(prod[i]) * QW'(RECIP_MULT);
      width_next[i] = q_full[i][RecipShift +: WidthW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid   <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (prod_ready) prod_valid <= color_valid;
      if (out_ready)  result.valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && color_valid) begin
      prod_color <= color;
      for (int i = 0; i < 3; i++) begin
        prod[i] <= ProdW'(lvl_in[i]) * ProdW'(period_load);
      end
    end
    if (out_ready && prod_valid) begin
      out_color <= prod_color;
      width     <= width_next;
    end
  end

  assign result.red_level   = out_color.red;
  assign result.green_level = out_color.green;
  assign result.blue_level  = out_color.blue;
  assign result.mode        = out_color.mode;
  assign result.red_width   = width[0];
  assign result.green_width = width[1];
  assign result.blue_width  = width[2];

endmodule

// File: rtl/rgb_led_mode_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_mode_controller
// Button gesture decoder and color fader with pulse width scaling.
// ----------------------------------------------------------------------------
// Takes one button tick per clock while the result side does not stall, and
// returns exactly one result per tick, in order. The gesture and fade state
// updates in the accepting cycle; the two following stages multiply each
// level by period_load and divide by 1000 with a reciprocal multiply, one
// multiplier per color in each stage. Write the configuration registers only
// while no tick is in flight.
module rgb_led_mode_controller (
  input  logic                       clk,
  input  logic                       rst,
  rlmc_tick_if.sink                  tick,
  rlmc_result_if.source              result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rlmc_pkg::AddrW-1:0] paddr,
  input  logic [rlmc_pkg::DataW-1:0] pwdata,
  output logic [rlmc_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import rlmc_pkg::*;

  cfg_t   cfg;
  logic   color_valid;
  color_t color;
  logic   pass_ready;

  rlmc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlmc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .tick        (tick),
    .pass_ready  (pass_ready),
    .color_valid (color_valid),
    .color       (color)
  );

  rlmc_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .period_load (cfg.period_load),
    .color_valid (color_valid),
    .color       (color),
    .pass_ready  (pass_ready),
    .result      (result)
  );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rgb led mode controller. Button ticks are
// driven on the tick channel. Each accepted tick is run through a local copy
// of the gesture and fade logic, which queues the expected color result.
// Every returned result is compared field by field against that queue. Both
// channels idle at random, and one long result stall backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import rlmc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_CYCLES = 120;

  // bit 0 is button one, bit 1 is button two
  typedef enum bit [1:0] {PRESS_NONE, PRESS_ONE, PRESS_TWO, PRESS_BOTH} press_t;
  typedef enum int {EP_GREEN, EP_RED, EP_BLUE, EP_NUDGE, EP_NOISE} episode_t;

  typedef struct packed {
    level_t            red;
    level_t            green;
    level_t            blue;
    logic [WidthW-1:0] red_w;
    logic [WidthW-1:0] green_w;
    logic [WidthW-1:0] blue_w;
    mode_t             mode;
  } color_out_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  rlmc_tick_if   tick_ch ();
  rlmc_result_if res_ch ();

  rgb_led_mode_controller dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the controller state
  int unsigned load_q;
  int unsigned long_ticks;
  int unsigned tmo_ticks;
  int unsigned hold_two;
  int unsigned hold_one;
  int unsigned presses;
  int unsigned released;
  mode_t       cur_mode;
  int unsigned red_lv;
  int unsigned green_lv;
  int unsigned blue_lv;
  int unsigned speed;
  bit          fade_rg;
  bit          fade_gb;
  bit          fade_br;

  color_out_t  pending_colors[$];
  press_t      steps[$];

  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  bit          idle_on;
  int unsigned rx_wait;
  int unsigned rx_hold;
  int unsigned quiet;

  function automatic void reset_leds();
    load_q     = PERIOD_LOAD_RST;
    long_ticks = LONG_PRESS_RST;
    tmo_ticks  = TIMEOUT_RST;
    hold_two   = 0;
    hold_one   = 0;
    presses    = 0;
    released   = 0;
    cur_mode   = MODE_AUTO;
    red_lv     = LEVEL_MAX;
    green_lv   = LEVEL_MIN;
    blue_lv    = LEVEL_MIN;
    fade_rg    = 1'b1;
    fade_gb    = 1'b0;
    fade_br    = 1'b0;
    speed      = SPEED_MIN;
  endfunction

  function automatic int unsigned clamp_level(int unsigned v);
    if (v < LEVEL_MIN) return LEVEL_MIN;
    if (v > LEVEL_MAX) return LEVEL_MAX;
    return v;
  endfunction

  // raise first, then lower
  function automatic int unsigned nudge(int unsigned v, bit up, bit down);
    if (up) v = clamp_level(v + 1);
    if (down) v = clamp_level(v - 1);
    return v;
  endfunction

  function automatic void take_gesture(mode_t m);
    cur_mode = m;
    red_lv   = LEVEL_MIN;
    green_lv = LEVEL_MIN;
    blue_lv  = LEVEL_MIN;
    case (m)
      MODE_RED:   red_lv = LEVEL_MAX;
      MODE_GREEN: green_lv = LEVEL_MAX;
      default:    blue_lv = LEVEL_MAX;
    endcase
    hold_two = 0;
    hold_one = 0;
    presses  = 0;
    released = 0;
  endfunction

  // one tick of the controller: update the shadow and queue the color result
  function automatic void step_leds(bit b1, bit b2);
    int unsigned d;
    color_out_t  c;
    if (b2) begin
      // fresh press of button two starts a new gesture
      if (hold_two == 0) begin
        hold_one = 0;
        presses  = 0;
        released = 0;
      end
      hold_two++;
      if (hold_two >= long_ticks) hold_two = long_ticks;
    end else begin
      hold_two = 0;
    end
    if (b1) begin
      if (hold_one < COUNT_MAX) hold_one++;
      released = 0;
      if (presses == 0 && hold_one >= long_ticks) hold_one = long_ticks;
    end else begin
      released++;
      if (released >= tmo_ticks) released = tmo_ticks;
      if (hold_one < long_ticks && hold_one > 0 && presses < PRESS_MAX) presses++;
      hold_one = 0;
    end
    if (hold_two == long_ticks) begin
      if (presses == 2) take_gesture(MODE_GREEN);
      else if (presses == 1 && released == tmo_ticks) take_gesture(MODE_RED);
      else if (hold_one == long_ticks) take_gesture(MODE_BLUE);
    end
    if (cur_mode == MODE_AUTO) begin
      d = speed / SpeedDiv;
      if (fade_rg) begin
        red_lv   = (red_lv >= d) ? red_lv - d : 0;
        green_lv = green_lv + d;
      end else if (fade_gb) begin
        green_lv = (green_lv >= d) ? green_lv - d : 0;
        blue_lv  = blue_lv + d;
      end else if (fade_br) begin
        blue_lv = (blue_lv >= d) ? blue_lv - d : 0;
        red_lv  = red_lv + d;
      end
      if (red_lv < LEVEL_MIN) red_lv = LEVEL_MIN;
      if (green_lv < LEVEL_MIN) green_lv = LEVEL_MIN;
      if (blue_lv < LEVEL_MIN) blue_lv = LEVEL_MIN;
      if (red_lv > LEVEL_MAX) begin
        red_lv  = LEVEL_MAX;
        fade_br = 1'b0;
        fade_rg = 1'b1;
      end
      if (green_lv > LEVEL_MAX) begin
        green_lv = LEVEL_MAX;
        fade_rg  = 1'b0;
        fade_gb  = 1'b1;
      end
      if (blue_lv > LEVEL_MAX) begin
        blue_lv = LEVEL_MAX;
        fade_gb = 1'b0;
        fade_br = 1'b1;
      end
      // both buttons: slow down first, then speed up
      if (b2 && speed > SPEED_MIN) speed--;
      if (b1 && speed < SPEED_MAX) speed++;
    end else begin
      case (cur_mode)
        MODE_RED:   red_lv = nudge(red_lv, b2, b1);
        MODE_GREEN: green_lv = nudge(green_lv, b2, b1);
        default:    blue_lv = nudge(blue_lv, b2, b1);
      endcase
    end
    c.red     = level_t'(red_lv);
    c.green   = level_t'(green_lv);
    c.blue    = level_t'(blue_lv);
    c.red_w   = WidthW'((longint'(red_lv) * load_q) / WidthDiv);
    c.green_w = WidthW'((longint'(green_lv) * load_q) / WidthDiv);
    c.blue_w  = WidthW'((longint'(blue_lv) * load_q) / WidthDiv);
    c.mode    = cur_mode;
    pending_colors.push_back(c);
  endfunction

  function automatic void compare(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_color();
    color_out_t want;
    results_seen++;
    if (pending_colors.size() == 0) begin
      $error("result transaction with no tick waiting for it");
      mismatches++;
      return;
    end
    want = pending_colors.pop_front();
    compare("red_level", want.red, res_ch.red_level);
    compare("green_level", want.green, res_ch.green_level);
    compare("blue_level", want.blue, res_ch.blue_level);
    compare("red_width", want.red_w, res_ch.red_width);
    compare("green_width", want.green_w, res_ch.green_width);
    compare("blue_width", want.blue_w, res_ch.blue_width);
    compare("mode", want.mode, res_ch.mode);
  endfunction

  // check results before predicting, both on pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) check_color();
      if (tick_ch.valid && tick_ch.ready)
        step_leds(tick_ch.button_one, tick_ch.button_two);
    end
  end

  // result side: random stall after each transaction, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_wait = 0;
    end else if (rx_hold != 0) begin
      rx_hold--;
      res_ch.ready <= 1'b0;
    end else if (res_ch.valid && res_ch.ready) begin
      rx_wait = idle_on ? $urandom_range(0, 3) : 0;
      res_ch.ready <= (rx_wait == 0);
    end else if (rx_wait != 0) begin
      rx_wait--;
      res_ch.ready <= (rx_wait == 0);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // longest quiet stretch is the requested stall plus a few idle cycles
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_tick(press_t p);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.button_one <= p[0];
    tick_ch.button_two <= p[1];
    do @(posedge clk); while (!tick_ch.ready);
    ticks_sent++;
  endtask

  function automatic press_t press_of(byte c);
    case (c)
      "1":     return PRESS_ONE;
      "2":     return PRESS_TWO;
      "3":     return PRESS_BOTH;
      default: return PRESS_NONE;
    endcase
  endfunction

  // '-' none, '1' button one, '2' button two, '3' both
  task automatic send_pattern(string s);
    for (int i = 0; i < s.len(); i++) send_tick(press_of(s[i]));
  endtask

  task automatic send_run(press_t p, int unsigned n);
    repeat (n) send_tick(p);
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (results_seen != ticks_sent) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PERIOD_LOAD: load_q = value[LoadW-1:0];
      REG_LONG_PRESS:  long_ticks = value[TicksW-1:0];
      default:         tmo_ticks = value[TicksW-1:0];
    endcase
  endtask

  task automatic configure(int unsigned load, int unsigned press_len, int unsigned timeout);
    drain();
    write_reg(REG_PERIOD_LOAD, load);
    write_reg(REG_LONG_PRESS, press_len);
    write_reg(REG_TIMEOUT, timeout);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void add_run(press_t p, int unsigned n);
    repeat (n) steps.push_back(p);
  endfunction

  // one gesture attempt with random timing, or a short burst of nudges or noise
  function automatic void build_episode(bit gestures);
    episode_t    kind;
    int unsigned tap;
    int unsigned n;
    kind = gestures ? episode_t'($urandom_range(0, 4)) : episode_t'($urandom_range(3, 4));
    if (long_ticks > 5) tap = $urandom_range(1, 4);
    else if (long_ticks > 1) tap = $urandom_range(1, long_ticks - 1);
    else tap = 1;
    case (kind)
      EP_GREEN: begin
        add_run(PRESS_NONE, $urandom_range(0, 1));
        add_run(PRESS_TWO, 1);
        repeat (2) begin
          add_run(PRESS_BOTH, tap);
          add_run(PRESS_TWO, $urandom_range(1, 3));
        end
        add_run(PRESS_TWO, long_ticks + $urandom_range(0, 1));
      end
      EP_RED: begin
        add_run(PRESS_NONE, $urandom_range(0, 1));
        add_run(PRESS_TWO, 1);
        add_run(PRESS_BOTH, tap);
        add_run(PRESS_TWO, (long_ticks > tmo_ticks ? long_ticks : tmo_ticks) +
                           $urandom_range(0, 2));
      end
      EP_BLUE: begin
        add_run(PRESS_NONE, $urandom_range(0, 1));
        add_run(PRESS_TWO, 1);
        add_run(PRESS_BOTH, long_ticks + $urandom_range(0, 2));
      end
      EP_NUDGE: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          add_run($urandom_range(0, 1) ? PRESS_ONE : PRESS_TWO, 1);
          add_run(PRESS_NONE, $urandom_range(0, 1));
        end
      end
      default: begin
        n = $urandom_range(1, 8);
        repeat (n) add_run(press_t'($urandom_range(0, 3)), 1);
      end
    endcase
    // now and then break the gesture with one wrong step
    if (gestures && $urandom_range(0, 4) == 0)
      steps[$urandom_range(0, steps.size() - 1)] = press_t'($urandom_range(0, 3));
  endfunction

  task automatic run_episodes(int unsigned n, bit gestures);
    int unsigned start;
    start = ticks_sent;
    while (ticks_sent - start < n) begin
      build_episode(gestures);
      foreach (steps[i]) send_tick(steps[i]);
      steps.delete();
    end
  endtask

  task automatic test_auto_fade();
    send_pattern("----1-2-3-113--2");
  endtask

  // speed up to the ceiling while the button-one hold count stops at the press
  // threshold, fade through the colors at full speed, then slow down a little
  task automatic test_speed_limits();
    configure(16'hFFFF, LONG_PRESS_RST, TIMEOUT_RST);
    send_run(PRESS_ONE, 100);
    send_run(PRESS_NONE, 10);
    repeat (2) begin
      send_run(PRESS_TWO, 9);
      send_tick(PRESS_NONE);
    end
    send_pattern("3-3-");
  endtask

  // random buttons in auto mode, button two never held long enough for a gesture
  task automatic test_auto_random();
    press_t      p;
    int unsigned run_two;
    configure($urandom_range(0, 16'hFFFF), LONG_PRESS_RST, TIMEOUT_RST);
    run_two = 0;
    repeat (30) begin
      idle_on = ($urandom_range(0, 3) != 0);
      p = press_t'($urandom_range(0, 3));
      if (run_two >= 15) p = press_t'({1'b0, p[0]});
      run_two = p[1] ? run_two + 1 : 0;
      send_tick(p);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_gestures();
    configure(PERIOD_LOAD_RST, 2, 2);
    send_pattern("-23232");   // two short presses: green
    send_pattern("13-");
    send_pattern("2322");     // one short press and a timeout: red
    send_pattern("-233");     // long hold of button one: blue
    // three short presses match nothing
    configure(PERIOD_LOAD_RST, 8, 2);
    send_pattern("-2323232222");
  endtask

  // after one short press the button-one hold count runs up to 255 while the
  // chosen level is walked down to the floor
  task automatic test_manual_limits();
    configure(16'hFFFF, LONG_PRESS_RST, TIMEOUT_RST);
    send_pattern("3-");
    send_run(PRESS_ONE, 258);
    send_pattern("3-2");
  endtask

  task automatic test_zero_thresholds();
    configure(PERIOD_LOAD_RST, 0, 0);
    send_pattern("-123-");
  endtask

  task automatic test_gesture_random();
    configure(16'hFFFF, 3, 2);
    run_episodes(30, 1'b1);
    configure(0, 1, 1);
    idle_on = 1'b0;
    run_episodes(15, 1'b1);
    idle_on = 1'b1;
    configure($urandom_range(0, 16'hFFFF), $urandom_range(2, 6), $urandom_range(1, 5));
    run_episodes(30, 1'b1);
    configure($urandom_range(0, 16'hFFFF), COUNT_MAX, COUNT_MAX);
    run_episodes(10, 1'b0);
  endtask

  // results held off while ticks keep coming, so the pipeline fills and stalls
  task automatic test_backpressure();
    configure($urandom_range(0, 16'hFFFF), 4, 3);
    idle_on = 1'b0;
    rx_hold = STALL_CYCLES;
    run_episodes(30, 1'b1);
    idle_on = 1'b1;
  endtask

  initial begin
    rst                <= 1'b1;
    tick_ch.valid      <= 1'b0;
    tick_ch.button_one <= 1'b0;
    tick_ch.button_two <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    idle_on            = 1'b1;
    rx_hold            = 0;
    reset_leds();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_auto_fade();
    test_speed_limits();
    test_auto_random();
    test_gestures();
    test_manual_limits();
    test_zero_thresholds();
    test_gesture_random();
    test_backpressure();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results from %0d ticks: auto fade, speed limits, gestures,",
             results_seen, ticks_sent);
    $display("manual level limits, zero thresholds and a %0d-cycle result stall",
             STALL_CYCLES);
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
